### rtl/core/urfq_pkg.sv
// ----------------------------------------------------------------------------
// urfq_pkg: shared types for the urgent-first record queue
// Operation, status and FSM state codes, record layout and the cell control bundle.
// ----------------------------------------------------------------------------
package urfq_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_POP    = 2'd1,
    OP_FIND   = 2'd2,
    OP_URGENT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] kind;
    logic [31:0] weight_bits;
    logic        urgent;
  } rec_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic        srch;      // item accepted: latch hit flags
    op_t         srch_op;   // operation of the accepted item
    logic [63:0] srch_key;  // search key of the accepted item
    logic        exec_app;  // append executes this cycle, queue not full
  } cell_ctl_t;

endpackage

### rtl/core/urfq_cell.sv
// ----------------------------------------------------------------------------
// urfq_cell: one queue slot
// Holds one record and its occupied flag, latches a hit flag on accept and
// takes its upper neighbor's record when a removal shifts the chain.
// ----------------------------------------------------------------------------
module urfq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  urfq_pkg::cell_ctl_t ctl,
  input  logic                shift_en,
  input  logic                prev_occ,
  input  logic                next_occ,
  input  urfq_pkg::rec_t      next_rec,
  input  urfq_pkg::rec_t      app_rec,
  output logic                occ,
  output urfq_pkg::rec_t      rec,
  output logic                hit
);

  logic           occ_r, occ_nxt;
  logic           hit_r, hit_nxt;
  urfq_pkg::rec_t rec_r, rec_nxt;
  logic           write_app;

  always_comb begin
    unique case (ctl.srch_op)
      urfq_pkg::OP_FIND:   hit_nxt = occ_r && (rec_r.key == ctl.srch_key);
      urfq_pkg::OP_URGENT: hit_nxt = occ_r && rec_r.urgent;
      urfq_pkg::OP_POP:    hit_nxt = occ_r;
      default:             hit_nxt = 1'b0;
    endcase
  end

  // the first free slot takes an appended record
  assign write_app = ctl.exec_app && !occ_r && prev_occ;

  always_comb begin
    occ_nxt = occ_r;
    rec_nxt = rec_r;
    priority if (shift_en) begin
      occ_nxt = next_occ;
      rec_nxt = next_rec;
    end else if (write_app) begin
      occ_nxt = 1'b1;
      rec_nxt = app_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (ctl.srch) begin
        hit_r <= hit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign occ = occ_r;
  assign rec = rec_r;
  assign hit = hit_r;

endmodule

### rtl/core/urfq_pick.sv
// ----------------------------------------------------------------------------
// urfq_pick: first-hit finder
// Prefix OR over the hit flags in log2(DEPTH) levels; gives the one-hot first
// hit and the span of slots from that hit to the tail.
// ----------------------------------------------------------------------------
module urfq_pick #(
  parameter int DEPTH = 16
) (
  input  logic [DEPTH-1:0] hit,
  output logic [DEPTH-1:0] first,
  output logic [DEPTH-1:0] span
);

  localparam int LOG = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DEPTH-1:0] lvl [LOG+1];

  always_comb begin
    lvl[0] = hit;
    for (int k = 0; k < LOG; k++) begin
      lvl[k+1] = lvl[k] | (lvl[k] << (1 << k));
    end
  end

  assign span  = lvl[LOG];
  assign first = span & ~(span << 1);

endmodule

### rtl/core/urgent_first_record_queue_core.sv
// ----------------------------------------------------------------------------
// urgent_first_record_queue_core: bounded record queue with urgent extract
// A chain of DEPTH slot cells, head at slot 0. Append, remove head, find by
// key and remove first urgent record (head if none), order kept.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   in_     | input     | in_valid/in_stall  | op, key, kind, weight_bits,
//           |           |                    | urgent
//   out_    | output    | out_valid/out_stall| status, key, kind, weight_bits,
//           |           |                    | urgent
//
// The accept edge latches a hit flag in every cell (key compare or urgent flag)
// and enters the execute state, which resolves the first hit with a prefix OR
// over all cells and shifts the chain; in_stall is high in the execute state.
// Reset (rst_n low, synchronous) empties the queue; slot contents stay as is.
// A stalled result holds the block in its execute cycle until it drains.
// ----------------------------------------------------------------------------
module urgent_first_record_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_key,
  input  logic [31:0] in_kind,
  input  logic [31:0] in_weight_bits,
  input  logic        in_urgent,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_key,
  output logic [31:0] out_kind,
  output logic [31:0] out_weight_bits,
  output logic        out_urgent
);

  urfq_pkg::fsm_t    state_r, state_nxt;
  urfq_pkg::op_t     op_r, op_nxt;
  urfq_pkg::rec_t    app_rec_r;
  urfq_pkg::cell_ctl_t ctl;

  logic              in_fire;
  logic              exec_fire;

  logic [DEPTH-1:0]  occ_vec;
  logic [DEPTH-1:0]  hit_vec;
  logic [DEPTH-1:0]  first_vec;
  logic [DEPTH-1:0]  span_vec;
  logic [DEPTH-1:0]  sel_vec;
  logic [DEPTH-1:0]  shift_vec;
  urfq_pkg::rec_t    rec_arr [DEPTH];

  logic              full;
  logic              nonempty;
  logic              any_hit;
  logic              fallback;
  logic              is_remove;
  urfq_pkg::status_t status;
  urfq_pkg::rec_t    sel_rec;
  urfq_pkg::rec_t    res_rec;

  logic              out_valid_r, out_valid_nxt;
  urfq_pkg::status_t out_status_r;
  urfq_pkg::rec_t    out_rec_r;

  // --- control ---------------------------------------------------------------
  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      urfq_pkg::FSM_IDLE: if (in_valid)  state_nxt = urfq_pkg::FSM_EXEC;
      urfq_pkg::FSM_EXEC: if (exec_fire) state_nxt = urfq_pkg::FSM_IDLE;
      default:            state_nxt = urfq_pkg::FSM_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    unique case (state_r)
      urfq_pkg::FSM_IDLE: begin
        in_stall  = 1'b0;
        exec_fire = 1'b0;
      end
      urfq_pkg::FSM_EXEC: begin
        in_stall  = 1'b1;
        exec_fire = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall  = 1'b1;
        exec_fire = 1'b0;
      end
    endcase
  end

  assign in_fire = in_valid && !in_stall;
  assign op_nxt  = in_fire ? urfq_pkg::op_t'(in_op) : op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= urfq_pkg::FSM_IDLE;
      op_r    <= urfq_pkg::OP_APPEND;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  // hold the record to append for the execute cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      app_rec_r.key         <= in_key;
      app_rec_r.kind        <= in_kind;
      app_rec_r.weight_bits <= in_weight_bits;
      app_rec_r.urgent      <= in_urgent;
    end
  end

  assign full     = occ_vec[DEPTH-1];
  assign nonempty = occ_vec[0];

  assign ctl.srch     = in_fire;
  assign ctl.srch_op  = urfq_pkg::op_t'(in_op);
  assign ctl.srch_key = in_key;
  assign ctl.exec_app = exec_fire && (op_r == urfq_pkg::OP_APPEND) && !full;

  // --- cell chain ------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic           prev_occ;
    logic           next_occ;
    urfq_pkg::rec_t next_rec;

    if (i == 0) begin : g_head
      assign prev_occ = 1'b1;
    end else begin : g_body
      assign prev_occ = occ_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_occ = 1'b0;
      assign next_rec = '0;
    end else begin : g_link
      assign next_occ = occ_vec[i+1];
      assign next_rec = rec_arr[i+1];
    end

    urfq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .shift_en (shift_vec[i]),
      .prev_occ (prev_occ),
      .next_occ (next_occ),
      .next_rec (next_rec),
      .app_rec  (app_rec_r),
      .occ      (occ_vec[i]),
      .rec      (rec_arr[i]),
      .hit      (hit_vec[i])
    );
  end

  // --- resolve the first hit -------------------------------------------------
  urfq_pick #(
    .DEPTH (DEPTH)
  ) u_pick (
    .hit   (hit_vec),
    .first (first_vec),
    .span  (span_vec)
  );

  assign any_hit   = span_vec[DEPTH-1];
  assign is_remove = (op_r == urfq_pkg::OP_POP) || (op_r == urfq_pkg::OP_URGENT);
  // no urgent record held: take the head instead
  assign fallback  = (op_r == urfq_pkg::OP_URGENT) && !any_hit;
  assign sel_vec   = fallback ? {{(DEPTH-1){1'b0}}, 1'b1} : first_vec;
  // close the gap: every slot from the removed one to the tail moves down
  assign shift_vec = (exec_fire && is_remove && nonempty)
                   ? (fallback ? {DEPTH{1'b1}} : span_vec) : '0;

  always_comb begin
    sel_rec = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_rec = sel_rec | (sel_vec[i] ? rec_arr[i] : '0);
    end
  end

  always_comb begin
    unique case (op_r)
      urfq_pkg::OP_APPEND: status = full ? urfq_pkg::STAT_FULL : urfq_pkg::STAT_OK;
      urfq_pkg::OP_FIND:   status = any_hit ? urfq_pkg::STAT_OK : urfq_pkg::STAT_NOTFOUND;
      default:             status = nonempty ? urfq_pkg::STAT_OK : urfq_pkg::STAT_EMPTY;
    endcase
  end

  // an append or an error returns a zero record
  assign res_rec = ((status == urfq_pkg::STAT_OK) && (op_r != urfq_pkg::OP_APPEND))
                 ? sel_rec : '0;

  // --- result register -------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_status_r <= status;
      out_rec_r    <= res_rec;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_key         = out_rec_r.key;
  assign out_kind        = out_rec_r.kind;
  assign out_weight_bits = out_rec_r.weight_bits;
  assign out_urgent      = out_rec_r.urgent;

  // --- assertions ------------------------------------------------------------
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |-> $onehot0(sel_vec))
    else $error("more than one slot selected");

  a_occ_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((occ_vec >> 1) & ~occ_vec) == '0)
    else $error("occupied slots not packed toward the head");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && is_remove && (status == urfq_pkg::STAT_OK))
    |=> ($countones(occ_vec) == $past($countones(occ_vec)) - 1))
    else $error("removal did not drop exactly one record");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec_app |=> ($countones(occ_vec) == $past($countones(occ_vec)) + 1))
    else $error("append did not add exactly one record");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != urfq_pkg::STAT_OK)) |-> (out_rec_r == '0))
    else $error("error result carries a nonzero record");

endmodule
